FILE: sv/rv32ex_pkg.sv
`timescale 1ns / 1ps

package rv32ex_pkg;

    localparam int XLEN = 32;
    localparam int DIV_STEPS = XLEN;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_REM    = 3'd6;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic [4:0]      dest_index;
        logic            dest_write;
        logic [XLEN-1:0] dest_value;
        logic [XLEN-1:0] next_pc;
        logic [1:0]      mem_kind;
        logic [1:0]      mem_size;
        logic            mem_unsigned;
        logic [XLEN-1:0] mem_address;
        logic [XLEN-1:0] store_data;
        logic            illegal;
        logic            md;
        logic [2:0]      f3;
    } rec_t;

    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] dvs;
        logic [XLEN-1:0] dvd;
        logic            neg_q;
        logic            neg_r;
        logic            bzero;
    } div_t;

    // one restoring step: one quotient bit
    function automatic div_t div_step(input div_t d);
        div_t o;
        logic [XLEN:0] r;
        logic [XLEN:0] t;
        o = d;
        r = {d.rem, d.quo[XLEN-1]};
        t = r - {1'b0, d.dvs};
        if (!t[XLEN]) begin
            o.rem = t[XLEN-1:0];
            o.quo = {d.quo[XLEN-2:0], 1'b1};
        end else begin
            o.rem = r[XLEN-1:0];
            o.quo = {d.quo[XLEN-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic rec_t decode(input logic [31:0] insn, input logic [31:0] pc,
                                    input logic [31:0] a, input logic [31:0] b);
        rec_t r;
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] immi, imms, immb, immj, immu, pc4;
        logic [4:0]  sh;
        logic        bad, c;
        op   = insn[6:0];
        rd   = insn[11:7];
        f3   = insn[14:12];
        f7   = insn[31:25];
        immi = {{20{insn[31]}}, insn[31:20]};
        imms = {{20{insn[31]}}, insn[31:25], insn[11:7]};
        immb = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
        immj = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
        immu = {insn[31:12], 12'h000};
        pc4  = pc + 32'd4;
        bad  = 1'b0;
        c    = 1'b0;
        sh   = 5'd0;
        r = '0;
        r.next_pc = pc4;
        r.f3 = f3;
        case (op)
            OPC_LUI: begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = immu;
            end
            OPC_AUIPC: begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = pc + immu;
            end
            OPC_JAL: begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = pc4;
                r.next_pc = pc + immj;
            end
            OPC_JALR: begin
                bad = (f3 != 3'd0);
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = pc4;
                r.next_pc = (a + immi) & ~32'd1;
            end
            OPC_BRANCH: begin
                case (f3[2:1])
                    2'd0: c = (a == b);
                    2'd2: c = ($signed(a) < $signed(b));
                    2'd3: c = (a < b);
                    default: bad = 1'b1;
                endcase
                if (c ^ f3[0])
                    r.next_pc = pc + immb;
            end
            OPC_LOAD: begin
                bad = (f3 == 3'd3) || (f3 > 3'd5);
                r.dest_index = rd; r.mem_kind = MEM_LOAD;
                r.mem_size = {1'b0, f3[0]} | {f3[1], 1'b0};
                r.mem_unsigned = f3[2];
                r.mem_address = a + immi;
            end
            OPC_STORE: begin
                bad = (f3 > 3'd2);
                r.mem_kind = MEM_STORE; r.mem_size = f3[1:0];
                r.mem_address = a + imms;
                case (f3[1:0])
                    SIZE_BYTE: r.store_data = {24'd0, b[7:0]};
                    SIZE_HALF: r.store_data = {16'd0, b[15:0]};
                    default:   r.store_data = b;
                endcase
            end
            OPC_OPIMM: begin
                sh = immi[4:0];
                r.dest_index = rd; r.dest_write = 1'b1;
                case (f3)
                    F3_ADD:  r.dest_value = a + immi;
                    F3_SLL: begin
                        bad = (f7 != F7_BASE);
                        r.dest_value = a << sh;
                    end
                    F3_SLT:  r.dest_value = {31'd0, $signed(a) < $signed(immi)};
                    F3_SLTU: r.dest_value = {31'd0, a < immi};
                    F3_XOR:  r.dest_value = a ^ immi;
                    F3_SRL: begin
                        bad = ((f7 & ~F7_ALT) != 7'd0);
                        r.dest_value = f7[5] ? 32'($signed(a) >>> sh) : a >> sh;
                    end
                    F3_OR:   r.dest_value = a | immi;
                    default: r.dest_value = a & immi;
                endcase
            end
            OPC_OP: begin
                sh = b[4:0];
                r.dest_index = rd; r.dest_write = 1'b1;
                if (f7 == F7_MULDIV) begin
                    r.md = 1'b1;
                end else if ((f7 & ~F7_ALT) != 7'd0) begin
                    bad = 1'b1;
                end else begin
                    case ({f7[5], f3})
                        {1'b0, F3_ADD}:  r.dest_value = a + b;
                        {1'b1, F3_ADD}:  r.dest_value = a - b;
                        {1'b0, F3_SLL}:  r.dest_value = a << sh;
                        {1'b0, F3_SLT}:  r.dest_value = {31'd0, $signed(a) < $signed(b)};
                        {1'b0, F3_SLTU}: r.dest_value = {31'd0, a < b};
                        {1'b0, F3_XOR}:  r.dest_value = a ^ b;
                        {1'b0, F3_SRL}:  r.dest_value = a >> sh;
                        {1'b1, F3_SRL}:  r.dest_value = 32'($signed(a) >>> sh);
                        {1'b0, F3_OR}:   r.dest_value = a | b;
                        {1'b0, F3_AND}:  r.dest_value = a & b;
                        default:         bad = 1'b1;
                    endcase
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            r = '0;
            r.next_pc = pc;
            r.illegal = 1'b1;
        end
        if (rd == 5'd0)
            r.dest_write = 1'b0;
        if (!r.dest_write)
            r.dest_value = '0;
        return r;
    endfunction

endpackage

FILE: sv/rv32im_execute_stage_core.sv
`timescale 1ns / 1ps

// Channel  Ports                                      Dir  Moves
// s_       s_valid s_ready s_instr_word s_cur_pc ...  in   instruction request
// m_       m_valid m_ready m_dest_index ... m_illegal out  execute result
//
// Fully pipelined: one request per cycle while m_ready does not stall it. A request
// accepted at an edge passes 35 register stages before m_valid (input register,
// decode/multiply stage, 32 one-bit divider stages, output).
// The divider chain sets the depth; every request flows through all stages.
// Reset (aresetn low, synchronous) clears the valid bits only.
// A stall on m_ready freezes the whole pipe; s_ready drops with it.
module rv32im_execute_stage_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instr_word,
    input  logic [31:0] s_cur_pc,
    input  logic [31:0] s_src1_value,
    input  logic [31:0] s_src2_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_dest_index,
    output logic        m_dest_write,
    output logic [31:0] m_dest_value,
    output logic [31:0] m_next_pc,
    output logic [1:0]  m_mem_kind,
    output logic [1:0]  m_mem_size,
    output logic        m_mem_unsigned,
    output logic [31:0] m_mem_address,
    output logic [31:0] m_store_data,
    output logic        m_illegal
);

    localparam int N = rv32ex_pkg::DIV_STEPS;

    logic en;

    logic        in_vld_reg;
    logic [31:0] in_insn_reg, in_pc_reg, in_a_reg, in_b_reg;

    logic               vld_reg [0:N];
    rv32ex_pkg::rec_t   rec_reg [0:N];
    rv32ex_pkg::div_t   dv_reg  [0:N];
    logic [63:0]        prod_reg;
    logic [31:0]        mul_a_reg, mul_b_reg;

    rv32ex_pkg::rec_t   dec_next;
    rv32ex_pkg::div_t   dv_next;
    logic               sgn_next;
    rv32ex_pkg::rec_t   rec1_next;
    logic [31:0]        hi_fix;

    logic               out_vld_reg;
    rv32ex_pkg::rec_t   out_reg, out_next;

    assign en = !out_vld_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
        if (en) begin
            in_insn_reg <= s_instr_word;
            in_pc_reg   <= s_cur_pc;
            in_a_reg    <= s_src1_value;
            in_b_reg    <= s_src2_value;
        end
    end

    always_comb begin
        dec_next = rv32ex_pkg::decode(in_insn_reg, in_pc_reg, in_a_reg, in_b_reg);
        sgn_next = (dec_next.f3 == rv32ex_pkg::F3_DIV) || (dec_next.f3 == rv32ex_pkg::F3_REM);
        dv_next.rem   = '0;
        dv_next.quo   = (sgn_next && in_a_reg[31]) ? 32'd0 - in_a_reg : in_a_reg;
        dv_next.dvs   = (sgn_next && in_b_reg[31]) ? 32'd0 - in_b_reg : in_b_reg;
        dv_next.dvd   = in_a_reg;
        dv_next.neg_q = sgn_next && (in_a_reg[31] ^ in_b_reg[31]);
        dv_next.neg_r = sgn_next && in_a_reg[31];
        dv_next.bzero = (in_b_reg == 32'd0);
    end

    // decode and multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld_reg;
        end
        if (en) begin
            rec_reg[0] <= dec_next;
            dv_reg[0]  <= dv_next;
            prod_reg   <= {32'd0, in_a_reg} * {32'd0, in_b_reg};
            mul_a_reg  <= in_a_reg;
            mul_b_reg  <= in_b_reg;
        end
    end

    // signed high-word correction from the unsigned product
    always_comb begin
        rec1_next = rec_reg[0];
        hi_fix = prod_reg[63:32];
        case (rec_reg[0].f3)
            rv32ex_pkg::F3_MULH:
                hi_fix = prod_reg[63:32] - (mul_a_reg[31] ? mul_b_reg : 32'd0)
                                         - (mul_b_reg[31] ? mul_a_reg : 32'd0);
            rv32ex_pkg::F3_MULHSU:
                hi_fix = prod_reg[63:32] - (mul_a_reg[31] ? mul_b_reg : 32'd0);
            default: hi_fix = prod_reg[63:32];
        endcase
        if (rec_reg[0].md && !rec_reg[0].f3[2]) begin
            rec1_next.dest_value = (rec_reg[0].f3 == rv32ex_pkg::F3_MUL) ?
                                   prod_reg[31:0] : hi_fix;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_div
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[gi+1] <= 1'b0;
                end else if (en) begin
                    vld_reg[gi+1] <= vld_reg[gi];
                end
                if (en) begin
                    dv_reg[gi+1] <= rv32ex_pkg::div_step(dv_reg[gi]);
                    if (gi == 0)
                        rec_reg[gi+1] <= rec1_next;
                    else
                        rec_reg[gi+1] <= rec_reg[gi];
                end
            end
        end
    endgenerate

    always_comb begin
        out_next = rec_reg[N];
        if (rec_reg[N].md && rec_reg[N].f3[2]) begin
            if (!rec_reg[N].f3[1]) begin
                if (dv_reg[N].bzero)
                    out_next.dest_value = '1;
                else
                    out_next.dest_value = dv_reg[N].neg_q ? 32'd0 - dv_reg[N].quo
                                                          : dv_reg[N].quo;
            end else begin
                if (dv_reg[N].bzero)
                    out_next.dest_value = dv_reg[N].dvd;
                else
                    out_next.dest_value = dv_reg[N].neg_r ? 32'd0 - dv_reg[N].rem
                                                          : dv_reg[N].rem;
            end
        end
        if (!rec_reg[N].dest_write)
            out_next.dest_value = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[N];
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_dest_index   = out_reg.dest_index;
    assign m_dest_write   = out_reg.dest_write;
    assign m_dest_value   = out_reg.dest_value;
    assign m_next_pc      = out_reg.next_pc;
    assign m_mem_kind     = out_reg.mem_kind;
    assign m_mem_size     = out_reg.mem_size;
    assign m_mem_unsigned = out_reg.mem_unsigned;
    assign m_mem_address  = out_reg.mem_address;
    assign m_store_data   = out_reg.store_data;
    assign m_illegal      = out_reg.illegal;

endmodule

FILE: verif/rv32im_execute_stage_core_tb.sv
`timescale 1ns / 1ps

module rv32im_execute_stage_core_tb;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] pc;
        logic [31:0] rs1;
        logic [31:0] rs2;
    } instr_req_t;

    typedef struct packed {
        logic [4:0]  dest_index;
        logic        dest_write;
        logic [31:0] dest_value;
        logic [31:0] next_pc;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size;
        logic        mem_unsigned;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        illegal;
    } exec_out_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_instr_word;
    logic [31:0] s_cur_pc;
    logic [31:0] s_src1_value;
    logic [31:0] s_src2_value;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_dest_index;
    logic        m_dest_write;
    logic [31:0] m_dest_value;
    logic [31:0] m_next_pc;
    logic [1:0]  m_mem_kind;
    logic [1:0]  m_mem_size;
    logic        m_mem_unsigned;
    logic [31:0] m_mem_address;
    logic [31:0] m_store_data;
    logic        m_illegal;

    instr_req_t pending_reqs[$];
    exec_out_t  expected_results[$];
    int         mismatch_count;
    int         results_seen;
    int         illegal_seen;
    bit         no_idle;
    bit         hold_sink;
    int         hold_cycles;
    bit         drain_pause;

    rv32im_execute_stage_core uut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] sx12(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] muldiv_value(input logic [2:0] f3,
                                                 input logic [31:0] a,
                                                 input logic [31:0] b);
        logic [63:0] p;
        logic [31:0] ma, mb, q, r;
        case (f3)
            rv32ex_pkg::F3_MUL:    return a * b;
            rv32ex_pkg::F3_MULH: begin
                p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                return p[63:32];
            end
            rv32ex_pkg::F3_MULHSU: begin
                p = {{32{a[31]}}, a} * {32'd0, b};
                return p[63:32];
            end
            rv32ex_pkg::F3_MULHU: begin
                p = {32'd0, a} * {32'd0, b};
                return p[63:32];
            end
            default: begin
                if (b == 32'd0)
                    return f3[1] ? a : 32'hffff_ffff;
                if (!f3[0]) begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    r = ma % mb;
                    if (f3[1])
                        return a[31] ? -r : r;
                    return (a[31] != b[31]) ? -q : q;
                end
                return f3[1] ? a % b : a / b;
            end
        endcase
    endfunction

    function automatic exec_out_t execute_instr(input instr_req_t q);
        exec_out_t o;
        logic [6:0]  op, f7;
        logic [4:0]  rd, sh;
        logic [2:0]  f3;
        logic [31:0] immi, a, b;
        logic        bad, taken;
        op = q.instr[6:0];
        rd = q.instr[11:7];
        f3 = q.instr[14:12];
        f7 = q.instr[31:25];
        immi = sx12(q.instr[31:20]);
        a = q.rs1;
        b = q.rs2;
        bad = 1'b0;
        taken = 1'b0;
        o = '0;
        o.next_pc = q.pc + 32'd4;
        case (op)
            rv32ex_pkg::OPC_LUI: begin
                o.dest_index = rd; o.dest_write = 1'b1;
                o.dest_value = {q.instr[31:12], 12'd0};
            end
            rv32ex_pkg::OPC_AUIPC: begin
                o.dest_index = rd; o.dest_write = 1'b1;
                o.dest_value = q.pc + {q.instr[31:12], 12'd0};
            end
            rv32ex_pkg::OPC_JAL: begin
                o.dest_index = rd; o.dest_write = 1'b1; o.dest_value = q.pc + 32'd4;
                o.next_pc = q.pc + {{12{q.instr[31]}}, q.instr[19:12], q.instr[20],
                                    q.instr[30:21], 1'b0};
            end
            rv32ex_pkg::OPC_JALR: begin
                if (f3 != 3'd0) bad = 1'b1;
                o.dest_index = rd; o.dest_write = 1'b1; o.dest_value = q.pc + 32'd4;
                o.next_pc = (a + immi) & 32'hffff_fffe;
            end
            rv32ex_pkg::OPC_BRANCH: begin
                case (f3[2:1])
                    2'd0: taken = (a == b);
                    2'd2: taken = ((a ^ 32'h8000_0000) < (b ^ 32'h8000_0000));
                    2'd3: taken = (a < b);
                    default: bad = 1'b1;
                endcase
                if (taken ^ f3[0])
                    o.next_pc = q.pc + {{20{q.instr[31]}}, q.instr[7], q.instr[30:25],
                                        q.instr[11:8], 1'b0};
            end
            rv32ex_pkg::OPC_LOAD: begin
                if (f3 == 3'd3 || f3 > 3'd5) bad = 1'b1;
                o.dest_index = rd; o.mem_kind = rv32ex_pkg::MEM_LOAD;
                o.mem_size = f3[1:0]; o.mem_unsigned = f3[2];
                o.mem_address = a + immi;
            end
            rv32ex_pkg::OPC_STORE: begin
                if (f3 > 3'd2) bad = 1'b1;
                o.mem_kind = rv32ex_pkg::MEM_STORE; o.mem_size = f3[1:0];
                o.mem_address = a + sx12({q.instr[31:25], q.instr[11:7]});
                o.store_data = (f3 == 3'd0) ? (b & 32'hff) :
                               (f3 == 3'd1) ? (b & 32'hffff) : b;
            end
            rv32ex_pkg::OPC_OPIMM: begin
                sh = immi[4:0];
                o.dest_index = rd; o.dest_write = 1'b1;
                case (f3)
                    rv32ex_pkg::F3_ADD:  o.dest_value = a + immi;
                    rv32ex_pkg::F3_SLL: begin
                        if (f7 != rv32ex_pkg::F7_BASE) bad = 1'b1;
                        o.dest_value = a << sh;
                    end
                    rv32ex_pkg::F3_SLT:
                        o.dest_value = ((a ^ 32'h8000_0000) < (immi ^ 32'h8000_0000));
                    rv32ex_pkg::F3_SLTU: o.dest_value = (a < immi);
                    rv32ex_pkg::F3_XOR:  o.dest_value = a ^ immi;
                    rv32ex_pkg::F3_SRL: begin
                        if ((f7 & ~rv32ex_pkg::F7_ALT) != 7'd0) bad = 1'b1;
                        o.dest_value = f7[5] ? ((a >> sh) | ~({32{1'b1}} >> sh) & {32{a[31]}})
                                             : a >> sh;
                    end
                    rv32ex_pkg::F3_OR:   o.dest_value = a | immi;
                    default: o.dest_value = a & immi;
                endcase
            end
            rv32ex_pkg::OPC_OP: begin
                sh = b[4:0];
                o.dest_index = rd; o.dest_write = 1'b1;
                if (f7 == rv32ex_pkg::F7_MULDIV)
                    o.dest_value = muldiv_value(f3, a, b);
                else if ((f7 & ~rv32ex_pkg::F7_ALT) != 7'd0)
                    bad = 1'b1;
                else if (f7[5] && f3 == rv32ex_pkg::F3_ADD)
                    o.dest_value = a - b;
                else if (f7[5] && f3 == rv32ex_pkg::F3_SRL)
                    o.dest_value = (a >> sh) | (~({32{1'b1}} >> sh) & {32{a[31]}});
                else if (f7[5])
                    bad = 1'b1;
                else
                    case (f3)
                        rv32ex_pkg::F3_ADD:  o.dest_value = a + b;
                        rv32ex_pkg::F3_SLL:  o.dest_value = a << sh;
                        rv32ex_pkg::F3_SLT:
                            o.dest_value = ((a ^ 32'h8000_0000) < (b ^ 32'h8000_0000));
                        rv32ex_pkg::F3_SLTU: o.dest_value = (a < b);
                        rv32ex_pkg::F3_XOR:  o.dest_value = a ^ b;
                        rv32ex_pkg::F3_SRL:  o.dest_value = a >> sh;
                        rv32ex_pkg::F3_OR:   o.dest_value = a | b;
                        default: o.dest_value = a & b;
                    endcase
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            o = '0;
            o.next_pc = q.pc;
            o.illegal = 1'b1;
        end
        if (rd == 5'd0) o.dest_write = 1'b0;
        if (!o.dest_write) o.dest_value = '0;
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed encodings with random fields, some raw noise
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        logic [6:0]  ops[9];
        ops = '{rv32ex_pkg::OPC_LUI, rv32ex_pkg::OPC_AUIPC, rv32ex_pkg::OPC_JAL,
                rv32ex_pkg::OPC_JALR, rv32ex_pkg::OPC_BRANCH, rv32ex_pkg::OPC_LOAD,
                rv32ex_pkg::OPC_STORE, rv32ex_pkg::OPC_OPIMM, rv32ex_pkg::OPC_OP};
        w = $urandom;
        if ($urandom_range(0, 9) == 0)
            return w;
        w[6:0] = ops[$urandom_range(0, 8)];
        if (w[6:0] == rv32ex_pkg::OPC_OP ||
            (w[6:0] == rv32ex_pkg::OPC_OPIMM && w[13:12] == 2'b01))
            case ($urandom_range(0, 4))
                0, 1: w[31:25] = rv32ex_pkg::F7_MULDIV;
                2: w[31:25] = rv32ex_pkg::F7_BASE;
                3: w[31:25] = rv32ex_pkg::F7_ALT;
                default: ;
            endcase
        return w;
    endfunction

    task automatic add_req(input logic [31:0] instr, input logic [31:0] a,
                           input logic [31:0] b);
        instr_req_t q;
        q.instr = instr;
        q.pc = ($urandom_range(0, 3) == 0) ? $urandom
                                            : {14'd0, 16'($urandom_range(0, 65535)), 2'b00};
        q.rs1 = a;
        q.rs2 = b;
        pending_reqs.push_back(q);
    endtask

    initial begin
        int i;
        add_req(32'h0000_0037, 32'd0, 32'd0);
        add_req(32'hffff_f0b7, 32'd0, 32'd0);
        add_req(32'h8000_0117, 32'd0, 32'd0);
        add_req(32'hfffff0ef, 32'd0, 32'd0);
        add_req(32'h800000ef, 32'd0, 32'd0);
        add_req(32'hfff08167, 32'h0000_1001, 32'd0);
        add_req(32'hfe208ee3, 32'd5, 32'd5);
        add_req(32'h7e20cfe3, 32'h8000_0000, 32'd1);
        add_req(32'h00202063, 32'd0, 32'd0);
        add_req(32'hfff0b183, 32'd0, 32'd0);
        add_req(32'h80054203, 32'hffff_ffff, 32'd0);
        add_req(32'hfe2faf23, 32'd100, 32'hdead_beef);
        add_req(32'h0020b023, 32'd0, 32'd0);
        add_req(32'h4010d293, 32'h8000_0000, 32'd0);
        add_req(32'h0210d293, 32'h8000_0000, 32'd0);
        add_req(32'h4020d333, 32'h8000_0000, 32'd31);
        add_req(32'h4020c333, 32'd1, 32'd2);
        add_req(32'h0220c3b3, 32'h8000_0000, 32'hffff_ffff);
        add_req(32'h0220e3b3, 32'h8000_0000, 32'hffff_ffff);
        add_req(32'h0220d433, 32'd7, 32'd0);
        add_req(32'h0220f433, 32'd7, 32'd0);
        add_req(32'h022094b3, 32'hffff_ffff, 32'hffff_ffff);
        add_req(32'h0220a4b3, 32'hffff_ffff, 32'hffff_ffff);
        add_req(32'h00000073, 32'd0, 32'd0);
        add_req(32'h0000000f, 32'd0, 32'd0);
        for (i = 0; i < 900; i++)
            add_req(rand_instr(), rand_operand(), rand_operand());
    end

    // driver
    always @(posedge aclk) begin
        instr_req_t q;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready)
                expected_results.push_back(execute_instr(pending_reqs.pop_front()));
            if (drain_pause && expected_results.size() == 0 && !(s_valid && s_ready))
                drain_pause <= 1'b0;
            if (pending_reqs.size() == 0 || drain_pause ||
                (!no_idle && $urandom_range(0, 99) < 14)) begin
                s_valid <= 1'b0;
            end else begin
                q = pending_reqs[0];
                s_valid      <= 1'b1;
                s_instr_word <= q.instr;
                s_cur_pc     <= q.pc;
                s_src1_value <= q.rs1;
                s_src2_value <= q.rs2;
            end
        end
    end

    // monitor and receiver
    always @(posedge aclk) begin
        exec_out_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_dest_index, m_dest_write, m_dest_value, m_next_pc, m_mem_kind,
                        m_mem_size, m_mem_unsigned, m_mem_address, m_store_data, m_illegal};
                results_seen++;
                if (got.illegal) illegal_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= hold_sink ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 14);
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_instr_word = '0;
        s_cur_pc = '0;
        s_src1_value = '0;
        s_src2_value = '0;
        m_ready = 1'b0;
        mismatch_count = 0;
        results_seen = 0;
        illegal_seen = 0;
        no_idle = 1'b0;
        hold_sink = 1'b0;
        hold_cycles = 0;
        drain_pause = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() < 700);
        @(posedge aclk);
        hold_cycles <= 120;
        wait (pending_reqs.size() < 500);
        @(posedge aclk);
        drain_pause <= 1'b1;
        wait (!drain_pause);
        @(posedge aclk);
        no_idle <= 1'b1;
        wait (pending_reqs.size() < 250);
        @(posedge aclk);
        no_idle <= 1'b0;
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (60) @(posedge aclk);
        $display("%0d instructions checked, %0d illegal; long output stall and drain covered",
                 results_seen, illegal_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/rv32ex_pkg.sv
sv/rv32im_execute_stage_core.sv
verif/rv32im_execute_stage_core_tb.sv
